// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define GHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is low.
`define GHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hw/rtl/gha_pkg.sv =====
`timescale 1ns / 1ps
package gha_pkg;

  localparam int unsigned SLOTS_DEF = 1024;

  localparam int unsigned HW  = 32;
  localparam int unsigned FW  = 24;
  localparam int unsigned GW  = 8;
  localparam int unsigned LCW = 11;

  localparam logic [1:0] KIND_CREATE  = 2'd0;
  localparam logic [1:0] KIND_DESTROY = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_QUERY   = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  // One classified word passed from the front to the back.
  typedef struct packed {
    op_t             op;
    logic            bad;
    logic [FW-1:0]   idx;
    logic [GW-1:0]   gen;
  } cmd_t;

endpackage

// ===== hw/rtl/gha_front.sv =====
`timescale 1ns / 1ps
module gha_front #(
  parameter int unsigned SLOTS = gha_pkg::SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [1:0]             kind,
  input  logic [gha_pkg::HW-1:0] handle_in,
  input  logic                   done,
  output logic                   busy,
  output logic                   push,
  output gha_pkg::cmd_t          cmd
);

  logic                   busy_r, busy_nxt;
  logic [gha_pkg::FW-1:0] field;

  assign field = handle_in[gha_pkg::FW-1:0];
  assign push  = start && !busy_r;
  assign busy  = busy_r;

  always_comb begin
    case (kind)
      gha_pkg::KIND_CREATE:  cmd.op = gha_pkg::OP_CREATE;
      gha_pkg::KIND_DESTROY: cmd.op = gha_pkg::OP_DESTROY;
      gha_pkg::KIND_QUERY:   cmd.op = gha_pkg::OP_QUERY;
      default:               cmd.op = gha_pkg::OP_NOP;
    endcase
    // A zero index field, or one past the table, can never name a slot.
    cmd.bad = (field == '0) || ({1'b0, field} > (gha_pkg::FW + 1)'(SLOTS));
    cmd.idx = field - gha_pkg::FW'(1);
    cmd.gen = handle_in[gha_pkg::HW-1:gha_pkg::FW];
  end

  always_comb begin
    busy_nxt = busy_r;
    if (push) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

endmodule

// ===== hw/rtl/gha_queue.sv =====
`timescale 1ns / 1ps
module gha_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gha_pkg::cmd_t push_data,
  input  logic          pop,
  output logic          empty,
  output gha_pkg::cmd_t head
);

  gha_pkg::cmd_t q_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;

  assign empty = (cnt_r == 2'd0);
  assign head  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/gha_back.sv =====
`timescale 1ns / 1ps
module gha_back #(
  parameter int unsigned SLOTS = gha_pkg::SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  gha_pkg::cmd_t           head,
  output logic                    pop,
  output logic                    done,
  output logic                    out_valid,
  output logic [gha_pkg::HW-1:0]  out_handle_out,
  output logic                    out_is_alive,
  output logic [1:0]              out_status,
  output logic [gha_pkg::LCW-1:0] out_live_num
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_POP  = 3'b010,
    ST_EXEC = 3'b100
  } st_t;

  st_t                    st_r, st_nxt;
  gha_pkg::cmd_t          cmd_r, cmd_nxt;
  logic [IW-1:0]          slot_r, slot_nxt;
  logic                   fresh_r, fresh_nxt;
  logic                   full_r, full_nxt;
  logic [CW-1:0]          fs_depth_r, fs_depth_nxt;
  logic [CW-1:0]          hwm_r, hwm_nxt;
  logic [CW-1:0]          live_r, live_nxt;

  logic [gha_pkg::GW-1:0] gen_mem   [SLOTS];
  logic                   alive_mem [SLOTS];
  logic [IW-1:0]          stack_mem [SLOTS];

  logic [gha_pkg::GW-1:0] gen_q_r;
  logic                   alive_q_r;
  logic [IW-1:0]          stack_q_r;
  logic [IW-1:0]          gen_raddr, stk_raddr;

  logic                   gen_we, alive_we, alive_wd, stk_we;
  logic [gha_pkg::GW-1:0] gen_old, gen_new;
  logic                   hit;

  logic                   res_valid;
  logic [gha_pkg::HW-1:0] res_handle;
  logic                   res_alive;
  logic [1:0]             res_status;

  logic                   out_valid_r;
  logic [gha_pkg::HW-1:0] out_handle_r;
  logic                   out_alive_r;
  logic [1:0]             out_status_r;
  logic [CW-1:0]          out_live_r;

  // While a create pops the free stack, the popped index steers the next read.
  assign gen_raddr = (st_r == ST_POP) ? stack_q_r : head.idx[IW-1:0];
  assign stk_raddr = IW'(fs_depth_r - CW'(1));

  assign gen_old = fresh_r ? '0 : gen_q_r;
  assign gen_new = ((gen_old + gha_pkg::GW'(1)) == '0) ? gha_pkg::GW'(1)
                                                       : gen_old + gha_pkg::GW'(1);
  assign hit = !cmd_r.bad && (CW'(slot_r) < hwm_r) && alive_q_r && (gen_q_r == cmd_r.gen);

  always_comb begin
    st_nxt       = st_r;
    cmd_nxt      = cmd_r;
    slot_nxt     = slot_r;
    fresh_nxt    = fresh_r;
    full_nxt     = full_r;
    fs_depth_nxt = fs_depth_r;
    hwm_nxt      = hwm_r;
    live_nxt     = live_r;
    pop          = 1'b0;
    gen_we       = 1'b0;
    alive_we     = 1'b0;
    alive_wd     = 1'b0;
    stk_we       = 1'b0;
    res_valid    = 1'b0;
    res_handle   = '0;
    res_alive    = 1'b0;
    res_status   = gha_pkg::STATUS_OK;
    case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          cmd_nxt   = head;
          slot_nxt  = head.idx[IW-1:0];
          fresh_nxt = 1'b0;
          full_nxt  = 1'b0;
          st_nxt    = ST_EXEC;
          if (head.op == gha_pkg::OP_CREATE) begin
            if (fs_depth_r != '0) begin
              fs_depth_nxt = fs_depth_r - CW'(1);
              st_nxt       = ST_POP;
            end else if (hwm_r < CW'(SLOTS)) begin
              fresh_nxt = 1'b1;
              slot_nxt  = hwm_r[IW-1:0];
              hwm_nxt   = hwm_r + CW'(1);
            end else begin
              full_nxt = 1'b1;
            end
          end
        end
      end
      ST_POP: begin
        slot_nxt = stack_q_r;
        st_nxt   = ST_EXEC;
      end
      ST_EXEC: begin
        st_nxt    = ST_IDLE;
        res_valid = 1'b1;
        case (cmd_r.op)
          gha_pkg::OP_CREATE: begin
            if (full_r) begin
              res_status = gha_pkg::STATUS_FULL;
            end else begin
              gen_we     = 1'b1;
              alive_we   = 1'b1;
              alive_wd   = 1'b1;
              live_nxt   = live_r + CW'(1);
              res_alive  = 1'b1;
              res_handle = {gen_new, gha_pkg::FW'(slot_r) + gha_pkg::FW'(1)};
            end
          end
          gha_pkg::OP_DESTROY, gha_pkg::OP_QUERY: begin
            if (hit) begin
              res_alive = 1'b1;
              if (cmd_r.op == gha_pkg::OP_DESTROY) begin
                alive_we = 1'b1;
                if (fs_depth_r < CW'(SLOTS)) begin
                  stk_we       = 1'b1;
                  fs_depth_nxt = fs_depth_r + CW'(1);
                end
                if (live_r != '0) begin
                  live_nxt = live_r - CW'(1);
                end
              end
            end else begin
              res_status = gha_pkg::STATUS_INVALID;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  assign done = res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      fs_depth_r  <= '0;
      hwm_r       <= '0;
      live_r      <= '0;
      fresh_r     <= 1'b0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      fs_depth_r  <= fs_depth_nxt;
      hwm_r       <= hwm_nxt;
      live_r      <= live_nxt;
      fresh_r     <= fresh_nxt;
      full_r      <= full_nxt;
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    slot_r <= slot_nxt;
    if (res_valid) begin
      out_handle_r <= res_handle;
      out_alive_r  <= res_alive;
      out_status_r <= res_status;
      out_live_r   <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gen_q_r   <= gen_mem[gen_raddr];
    alive_q_r <= alive_mem[gen_raddr];
    stack_q_r <= stack_mem[stk_raddr];
    if (gen_we) begin
      gen_mem[slot_r] <= gen_new;
    end
    if (alive_we) begin
      alive_mem[slot_r] <= alive_wd;
    end
    if (stk_we) begin
      stack_mem[fs_depth_r[IW-1:0]] <= slot_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_handle_out = out_handle_r;
  assign out_is_alive   = out_alive_r;
  assign out_status     = out_status_r;
  assign out_live_num   = gha_pkg::LCW'(out_live_r);

endmodule

// ===== hw/rtl/generational_handle_allocator_top.sv =====
`timescale 1ns / 1ps
// Channel   Handshake          Word
// in        start / busy       in_kind, in_handle_in
// out       out_valid strobe   out_handle_out, out_is_alive, out_status, out_live_num
//
// An accepted word is queued, popped by the back end and executed there, with a pop of
// the free stack first for a create that reuses a freed slot; the result is registered.
// busy is high from the accept edge until the edge that loads the result, so the
// next word may be accepted while the previous result is on the out ports.
// Synchronous active-low reset empties the free stack and zeroes all counters.
// The receiver cannot stall; each result shows for exactly one cycle.
module generational_handle_allocator_top #(
  parameter int unsigned SLOTS = gha_pkg::SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_kind,
  input  logic [gha_pkg::HW-1:0]  in_handle_in,
  output logic                    out_valid,
  output logic [gha_pkg::HW-1:0]  out_handle_out,
  output logic                    out_is_alive,
  output logic [1:0]              out_status,
  output logic [gha_pkg::LCW-1:0] out_live_num
);

  logic          push, pop, q_empty, done;
  gha_pkg::cmd_t cmd, head;

  gha_front #(.SLOTS(SLOTS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .kind      (in_kind),
    .handle_in (in_handle_in),
    .done      (done),
    .busy      (busy),
    .push      (push),
    .cmd       (cmd)
  );

  gha_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cmd),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  gha_back #(.SLOTS(SLOTS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .head           (head),
    .pop            (pop),
    .done           (done),
    .out_valid      (out_valid),
    .out_handle_out (out_handle_out),
    .out_is_alive   (out_is_alive),
    .out_status     (out_status),
    .out_live_num   (out_live_num)
  );

endmodule

// ===== hw/rtl/gha_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gha_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_valid,
  input logic [gha_pkg::HW-1:0] out_handle_out,
  input logic                   out_is_alive,
  input logic [1:0]             out_status
);

  logic accept;
  logic fail_word;
  logic handle_given;
  logic handle_formed;

  assign accept    = start && !busy;
  assign fail_word = out_valid && (out_status == gha_pkg::STATUS_FULL ||
                                   out_status == gha_pkg::STATUS_INVALID);
  assign handle_given  = out_valid && out_handle_out != '0;
  assign handle_formed = out_is_alive && out_handle_out[gha_pkg::HW-1:gha_pkg::FW] != '0 &&
                         out_handle_out[gha_pkg::FW-1:0] != '0;

  // An accepted word keeps the block busy until its result is loaded.
  `GHA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, busy)

  // One word is in flight at a time, so results never come back to back.
  `GHA_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)

  // A failed operation never hands out a handle or reports it alive.
  `GHA_ASSERT_IMP(a_fail_clean, clk, rst_n, fail_word, out_handle_out == '0 && !out_is_alive)

  // Any handle handed out has a nonzero generation and a nonzero index field.
  `GHA_ASSERT_IMP(a_handle_form, clk, rst_n, handle_given, handle_formed)

endmodule

bind generational_handle_allocator_top gha_checker u_gha_checker (.*);
